// ===== rtl/core/erhw_pkg.sv =====
// Shared widths, microcode encodings and the control store for the ellipse span generator.
package erhw_pkg;

    localparam int RAD_W  = 6;
    localparam int ROW_W  = 6;
    localparam int HW_W   = 6;
    localparam int COL_W  = 7;
    localparam int SQ_W   = 12;
    localparam int DX_W   = 20;
    localparam int DY_W   = 19;
    localparam int D_W    = 32;
    localparam int MX_W   = 16;
    localparam int PROD_W = MX_W + SQ_W;
    localparam int PC_W   = 4;

    localparam logic [RAD_W-1:0] RADIUS_MAX = 6'd63;
    localparam logic [HW_W-1:0]  FIELD6_MAX = 6'd63;

    // multiplier operand selects
    typedef logic [3:0] t_mul;
    localparam t_mul MUL_NONE = 4'd0;
    localparam t_mul MUL_AA   = 4'd1;
    localparam t_mul MUL_BB   = 4'd2;
    localparam t_mul MUL_A2B  = 4'd3;
    localparam t_mul MUL_TT   = 4'd4;
    localparam t_mul MUL_B2P  = 4'd5;
    localparam t_mul MUL_RR   = 4'd6;
    localparam t_mul MUL_A2P  = 4'd7;
    localparam t_mul MUL_A2B2 = 4'd8;

    // register update operations
    typedef logic [3:0] t_alu;
    localparam t_alu ALU_NOP   = 4'd0;
    localparam t_alu ALU_LOAD  = 4'd1;
    localparam t_alu ALU_A2    = 4'd2;
    localparam t_alu ALU_B2    = 4'd3;
    localparam t_alu ALU_INIT1 = 4'd4;
    localparam t_alu ALU_R1    = 4'd5;
    localparam t_alu ALU_DLOAD = 4'd6;
    localparam t_alu ALU_DADD  = 4'd7;
    localparam t_alu ALU_DSUB  = 4'd8;
    localparam t_alu ALU_R2    = 4'd9;

    // jump conditions
    typedef logic [1:0] t_cond;
    localparam t_cond COND_ALWAYS = 2'd0;
    localparam t_cond COND_START  = 2'd1;
    localparam t_cond COND_R1EXIT = 2'd2;
    localparam t_cond COND_ROW0   = 2'd3;

    typedef logic [PC_W-1:0] t_pc;
    localparam t_pc ST_IDLE  = 4'd0;
    localparam t_pc ST_SQA   = 4'd1;
    localparam t_pc ST_SQB   = 4'd2;
    localparam t_pc ST_A2B   = 4'd3;
    localparam t_pc ST_INIT1 = 4'd4;
    localparam t_pc ST_R1    = 4'd5;
    localparam t_pc ST_TT    = 4'd6;
    localparam t_pc ST_B2T   = 4'd7;
    localparam t_pc ST_RR    = 4'd8;
    localparam t_pc ST_A2R   = 4'd9;
    localparam t_pc ST_A2B2  = 4'd10;
    localparam t_pc ST_DSUB  = 4'd11;
    localparam t_pc ST_R2    = 4'd12;

    typedef struct packed {
        t_mul  mul;
        t_alu  alu;
        t_cond cond;
        t_pc   tgt_t;
        t_pc   tgt_f;
    } t_ctrl;

    typedef struct packed {
        logic start;
        logic r1_exit;
        logic row_zero;
        logic emit_req;
        logic out_free;
    } t_stat;

    // Control store. A multiply result lands in the product register and is
    // consumed by the following step.
    function automatic t_ctrl ucode(input t_pc pc);
        t_ctrl w;
        unique case (pc)
            ST_IDLE:  w = '{MUL_NONE, ALU_LOAD,  COND_START,  ST_SQA,   ST_IDLE};
            ST_SQA:   w = '{MUL_AA,   ALU_NOP,   COND_ALWAYS, ST_SQB,   ST_SQB};
            ST_SQB:   w = '{MUL_BB,   ALU_A2,    COND_ALWAYS, ST_A2B,   ST_A2B};
            ST_A2B:   w = '{MUL_A2B,  ALU_B2,    COND_ALWAYS, ST_INIT1, ST_INIT1};
            ST_INIT1: w = '{MUL_NONE, ALU_INIT1, COND_ALWAYS, ST_R1,    ST_R1};
            ST_R1:    w = '{MUL_NONE, ALU_R1,    COND_R1EXIT, ST_TT,    ST_R1};
            ST_TT:    w = '{MUL_TT,   ALU_NOP,   COND_ALWAYS, ST_B2T,   ST_B2T};
            ST_B2T:   w = '{MUL_B2P,  ALU_NOP,   COND_ALWAYS, ST_RR,    ST_RR};
            ST_RR:    w = '{MUL_RR,   ALU_DLOAD, COND_ALWAYS, ST_A2R,   ST_A2R};
            ST_A2R:   w = '{MUL_A2P,  ALU_NOP,   COND_ALWAYS, ST_A2B2,  ST_A2B2};
            ST_A2B2:  w = '{MUL_A2B2, ALU_DADD,  COND_ALWAYS, ST_DSUB,  ST_DSUB};
            ST_DSUB:  w = '{MUL_NONE, ALU_DSUB,  COND_ALWAYS, ST_R2,    ST_R2};
            ST_R2:    w = '{MUL_NONE, ALU_R2,    COND_ROW0,   ST_IDLE,  ST_R2};
            default:  w = '{MUL_NONE, ALU_NOP,   COND_ALWAYS, ST_IDLE,  ST_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/core/erhw_if.sv =====
// Request and span channel interfaces.
interface erhw_req_if;
    logic                        valid;
    logic                        ready;
    logic [erhw_pkg::RAD_W-1:0]  radius_x;
    logic [erhw_pkg::RAD_W-1:0]  radius_y;

    modport source (output valid, output radius_x, output radius_y, input ready);
    modport sink   (input valid, input radius_x, input radius_y, output ready);
endinterface

interface erhw_span_if;
    logic                        valid;
    logic                        ready;
    logic [erhw_pkg::ROW_W-1:0]  row;
    logic [erhw_pkg::HW_W-1:0]   half_width;
    logic                        last;

    modport source (output valid, output row, output half_width, output last, input ready);
    modport sink   (input valid, input row, input half_width, input last, output ready);
endinterface

// ===== rtl/core/ellipse_row_half_widths.sv =====
// Ellipse row half-width generator: midpoint ellipse walk emitting one span per row.
//
// Usage: a request on i_req carries radius_x and radius_y. The block answers
// with radius_y + 1 transfers on o_span, one per row from row = radius_y down
// to row 0, each giving the half-width of the filled span in that row; the
// transfer for row 0 has last set. Radii above RADIUS_MAX saturate.
// i_req.ready is high only while the sequencer sits in its idle step, so one
// request is in flight at a time; the next is taken the cycle after the final
// span has been loaded into the output register.
// Steps: the accepting idle step and four setup steps (squares and initial
// decision) come first, then one step per region-1 column move plus one exit
// step, six steps to seed region 2, then one step per remaining row. The
// request is worked through by the single shared multiply/accumulate datapath,
// which executes one microcode step per cycle unless a step that must emit a
// span is held waiting for room in the output register.
// A stalled receiver holds the span in the output register; any step that must
// emit another span waits until the register frees up.
// Reset returns the sequencer to idle and drops o_span.valid; the datapath
// registers are loaded by each new request.
module ellipse_row_half_widths #(
    parameter logic [erhw_pkg::RAD_W-1:0] RADIUS_MAX = erhw_pkg::RADIUS_MAX
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    erhw_req_if.sink    i_req,
    erhw_span_if.source o_span
);

    erhw_pkg::t_ctrl w_ctrl;
    erhw_pkg::t_stat w_stat;
    logic            w_go;

    erhw_sequencer u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl),
        .o_go    (w_go)
    );

    erhw_datapath #(
        .RADIUS_MAX (RADIUS_MAX)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .i_go    (w_go),
        .o_stat  (w_stat),
        .i_req   (i_req),
        .o_span  (o_span)
    );

endmodule

// ===== rtl/core/erhw_sequencer.sv =====
// Step counter and control store with conditional jumps.
module erhw_sequencer (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  erhw_pkg::t_stat i_stat,
    output erhw_pkg::t_ctrl o_ctrl,
    output logic            o_go
);

    erhw_pkg::t_pc r_pc;
    erhw_pkg::t_pc n_pc;
    logic          w_cond;

    assign o_ctrl = erhw_pkg::ucode(r_pc);

    // a step that emits a span waits for room in the output register
    assign o_go = !i_stat.emit_req || i_stat.out_free;

    always_comb begin
        unique case (o_ctrl.cond)
            erhw_pkg::COND_ALWAYS: w_cond = 1'b1;
            erhw_pkg::COND_START:  w_cond = i_stat.start;
            erhw_pkg::COND_R1EXIT: w_cond = i_stat.r1_exit;
            erhw_pkg::COND_ROW0:   w_cond = i_stat.row_zero;
            default:               w_cond = 1'b0;
        endcase
        if (o_go) begin
            n_pc = w_cond ? o_ctrl.tgt_t : o_ctrl.tgt_f;
        end else begin
            n_pc = r_pc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= erhw_pkg::ST_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

// ===== rtl/core/erhw_datapath.sv =====
// Decision datapath: shared multiplier, step registers and the span output register.
module erhw_datapath #(
    parameter logic [erhw_pkg::RAD_W-1:0] RADIUS_MAX = erhw_pkg::RADIUS_MAX
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  erhw_pkg::t_ctrl i_ctrl,
    input  logic            i_go,
    output erhw_pkg::t_stat o_stat,
    erhw_req_if.sink        i_req,
    erhw_span_if.source     o_span
);

    localparam int D_W = erhw_pkg::D_W;

    logic [erhw_pkg::RAD_W-1:0]  r_a;
    logic [erhw_pkg::RAD_W-1:0]  r_b;
    logic [erhw_pkg::SQ_W-1:0]   r_a2;
    logic [erhw_pkg::SQ_W-1:0]   r_b2;
    logic [erhw_pkg::COL_W-1:0]  r_col;
    logic [erhw_pkg::ROW_W-1:0]  r_row;
    logic [erhw_pkg::DX_W-1:0]   r_dx;
    logic [erhw_pkg::DY_W-1:0]   r_dy;
    logic signed [D_W-1:0]       r_d;
    logic [erhw_pkg::PROD_W-1:0] r_prod;

    logic                        r_ovalid;
    logic [erhw_pkg::ROW_W-1:0]  r_orow;
    logic [erhw_pkg::HW_W-1:0]   r_ohw;
    logic                        r_olast;

    logic                        w_start;
    logic [erhw_pkg::RAD_W-1:0]  w_rx;
    logic [erhw_pkg::RAD_W-1:0]  w_ry;
    logic [erhw_pkg::SQ_W:0]     w_two_a2;
    logic [erhw_pkg::SQ_W:0]     w_two_b2;
    logic [erhw_pkg::COL_W:0]    w_t;
    logic [erhw_pkg::ROW_W-1:0]  w_rm;
    logic [erhw_pkg::MX_W-1:0]   w_mx;
    logic [erhw_pkg::SQ_W-1:0]   w_my;
    logic [erhw_pkg::PROD_W-1:0] w_prod;
    logic                        w_r1_exit;
    logic                        w_d_neg;
    logic                        w_d_pos;
    logic                        w_row_zero;
    logic                        w_emit;
    logic                        w_out_free;
    logic [erhw_pkg::HW_W-1:0]   w_hw;
    logic [erhw_pkg::DX_W-1:0]   w_dx_new;
    logic [erhw_pkg::DY_W-1:0]   w_dy_new;
    logic signed [D_W-1:0]       w_a2_d;
    logic signed [D_W-1:0]       w_b2_d;
    logic signed [D_W-1:0]       w_dx_d;
    logic signed [D_W-1:0]       w_dxn_d;
    logic signed [D_W-1:0]       w_dy_d;
    logic signed [D_W-1:0]       w_dyn_d;
    logic signed [D_W-1:0]       w_prod_d;
    logic signed [D_W-1:0]       w_d_r1;
    logic signed [D_W-1:0]       w_d_r2;

    assign i_req.ready = (i_ctrl.alu == erhw_pkg::ALU_LOAD);
    assign w_start     = i_req.valid && i_req.ready;

    assign w_rx = (i_req.radius_x > RADIUS_MAX) ? RADIUS_MAX : i_req.radius_x;
    assign w_ry = (i_req.radius_y > RADIUS_MAX) ? RADIUS_MAX : i_req.radius_y;

    assign w_two_a2 = {r_a2, 1'b0};
    assign w_two_b2 = {r_b2, 1'b0};
    assign w_t      = {r_col, 1'b1};
    // |row - 1|, so the square is right when the walk ends region 1 on row 0
    assign w_rm     = (r_row == '0) ? erhw_pkg::ROW_W'(1) : (r_row - erhw_pkg::ROW_W'(1));

    always_comb begin
        unique case (i_ctrl.mul)
            erhw_pkg::MUL_AA: begin
                w_mx = erhw_pkg::MX_W'(r_a);
                w_my = erhw_pkg::SQ_W'(r_a);
            end
            erhw_pkg::MUL_BB: begin
                w_mx = erhw_pkg::MX_W'(r_b);
                w_my = erhw_pkg::SQ_W'(r_b);
            end
            erhw_pkg::MUL_A2B: begin
                w_mx = erhw_pkg::MX_W'(r_b);
                w_my = r_a2;
            end
            erhw_pkg::MUL_TT: begin
                w_mx = erhw_pkg::MX_W'(w_t);
                w_my = erhw_pkg::SQ_W'(w_t);
            end
            erhw_pkg::MUL_B2P: begin
                w_mx = r_prod[erhw_pkg::MX_W-1:0];
                w_my = r_b2;
            end
            erhw_pkg::MUL_RR: begin
                w_mx = erhw_pkg::MX_W'(w_rm);
                w_my = erhw_pkg::SQ_W'(w_rm);
            end
            erhw_pkg::MUL_A2P: begin
                w_mx = r_prod[erhw_pkg::MX_W-1:0];
                w_my = r_a2;
            end
            erhw_pkg::MUL_A2B2: begin
                w_mx = erhw_pkg::MX_W'(r_b2);
                w_my = r_a2;
            end
            default: begin
                w_mx = '0;
                w_my = '0;
            end
        endcase
    end

    assign w_prod = erhw_pkg::PROD_W'(w_mx) * erhw_pkg::PROD_W'(w_my);

    assign w_a2_d   = D_W'(r_a2);
    assign w_b2_d   = D_W'(r_b2);
    assign w_dx_d   = D_W'(r_dx);
    assign w_dy_d   = D_W'(r_dy);
    assign w_prod_d = D_W'(r_prod);

    assign w_dx_new = r_dx + erhw_pkg::DX_W'(w_two_b2);
    assign w_dy_new = r_dy - erhw_pkg::DY_W'(w_two_a2);
    assign w_dxn_d  = D_W'(w_dx_new);
    assign w_dyn_d  = D_W'(w_dy_new);

    assign w_d_neg    = r_d[D_W-1];
    assign w_d_pos    = !w_d_neg && (r_d != '0);
    assign w_r1_exit  = !(r_dx < erhw_pkg::DX_W'(r_dy));
    assign w_row_zero = (r_row == '0);

    // region 1: column step, row steps down only when the decision is not negative
    assign w_d_r1 = r_d + w_b2_d + w_dxn_d - (w_d_neg ? '0 : w_dy_d);
    // region 2: row step, column steps when the decision is not positive
    assign w_d_r2 = r_d + w_a2_d - w_dyn_d + (w_d_pos ? '0 : w_dx_d);

    assign w_emit = ((i_ctrl.alu == erhw_pkg::ALU_R1) && !w_r1_exit && !w_d_neg)
                 || (i_ctrl.alu == erhw_pkg::ALU_R2);

    assign w_out_free = !r_ovalid || o_span.ready;
    assign w_hw = r_col[erhw_pkg::COL_W-1] ? erhw_pkg::FIELD6_MAX : r_col[erhw_pkg::HW_W-1:0];

    assign o_stat = '{start:    w_start,
                      r1_exit:  w_r1_exit,
                      row_zero: w_row_zero,
                      emit_req: w_emit,
                      out_free: w_out_free};

    always_ff @(posedge i_clk) begin
        if (i_go && (i_ctrl.mul != erhw_pkg::MUL_NONE)) begin
            r_prod <= w_prod;
        end
        if (i_go) begin
            unique case (i_ctrl.alu)
                erhw_pkg::ALU_LOAD: begin
                    if (w_start) begin
                        r_a   <= w_rx;
                        r_b   <= w_ry;
                        r_col <= '0;
                        r_row <= w_ry;
                    end
                end
                erhw_pkg::ALU_A2: begin
                    r_a2 <= r_prod[erhw_pkg::SQ_W-1:0];
                end
                erhw_pkg::ALU_B2: begin
                    r_b2 <= r_prod[erhw_pkg::SQ_W-1:0];
                end
                erhw_pkg::ALU_INIT1: begin
                    r_d  <= w_b2_d - w_prod_d + (w_a2_d >>> 2);
                    r_dx <= '0;
                    r_dy <= {r_prod[erhw_pkg::DY_W-2:0], 1'b0};
                end
                erhw_pkg::ALU_R1: begin
                    if (!w_r1_exit) begin
                        r_col <= r_col + erhw_pkg::COL_W'(1);
                        r_dx  <= w_dx_new;
                        r_d   <= w_d_r1;
                        if (!w_d_neg) begin
                            r_row <= r_row - erhw_pkg::ROW_W'(1);
                            r_dy  <= w_dy_new;
                        end
                    end
                end
                erhw_pkg::ALU_DLOAD: begin
                    r_d <= w_prod_d >>> 2;
                end
                erhw_pkg::ALU_DADD: begin
                    r_d <= r_d + w_prod_d;
                end
                erhw_pkg::ALU_DSUB: begin
                    r_d <= r_d - w_prod_d;
                end
                erhw_pkg::ALU_R2: begin
                    if (!w_row_zero) begin
                        r_row <= r_row - erhw_pkg::ROW_W'(1);
                        r_dy  <= w_dy_new;
                        r_d   <= w_d_r2;
                        if (!w_d_pos) begin
                            r_col <= r_col + erhw_pkg::COL_W'(1);
                            r_dx  <= w_dx_new;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // span output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_emit && i_go) begin
            r_ovalid <= 1'b1;
        end else if (o_span.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit && i_go) begin
            r_orow  <= r_row;
            r_ohw   <= w_hw;
            r_olast <= w_row_zero;
        end
    end

    assign o_span.valid      = r_ovalid;
    assign o_span.row        = r_orow;
    assign o_span.half_width = r_ohw;
    assign o_span.last       = r_olast;

endmodule

// ===== test/erhw_span_checker.sv =====
// Channel monitor: predicts the span run of every request and compares each span transfer.
module erhw_span_checker (
    input  logic   i_clk,
    input  logic   i_rst_n,
    erhw_req_if    i_req,
    erhw_span_if   i_span,
    output int     o_fail_count,
    output int     o_pending,
    output int     o_spans_checked,
    output int     o_requests
);
    import erhw_pkg::*;

    typedef struct {
        logic [ROW_W-1:0] row;
        logic [HW_W-1:0]  half_width;
        logic             last;
    } t_span_exp;

    t_span_exp expected_spans[$];
    int        run_len       = 0;
    int        fail_count    = 0;
    int        spans_checked = 0;
    int        requests      = 0;

    assign o_fail_count    = fail_count;
    assign o_spans_checked = spans_checked;
    assign o_requests      = requests;

    task automatic flag_mismatch(input string msg);
        fail_count++;
        $display("mismatch @%0t: %s", $time, msg);
    endtask

    // one expected span, clamped to the 6-bit fields; a run never exceeds 64 spans
    function automatic void queue_span(input longint rw, input longint hw);
        t_span_exp s;
        if (run_len >= 64)
            return;
        s.row        = (rw < 0) ? '0 : (rw > FIELD6_MAX) ? FIELD6_MAX : rw[ROW_W-1:0];
        s.half_width = (hw < 0) ? '0 : (hw > FIELD6_MAX) ? FIELD6_MAX : hw[HW_W-1:0];
        s.last       = (rw == 0);
        expected_spans.push_back(s);
        run_len++;
    endfunction

    // two-region midpoint ellipse walk over the upper-right quadrant
    function automatic void predict_row_spans(input logic [RAD_W-1:0] rx,
                                              input logic [RAD_W-1:0] ry);
        longint a, b, a2, b2, two_a2, two_b2, col, rw, dec, t;
        a      = rx;
        b      = ry;
        a2     = a * a;
        b2     = b * b;
        two_a2 = 2 * a2;
        two_b2 = 2 * b2;
        run_len = 0;
        col    = 0;
        rw     = b;
        dec    = b2 - a2 * b + a2 / 4;
        // shallow slope: a span leaves only when the row steps down
        while (two_b2 * col < two_a2 * rw) begin
            col++;
            if (dec < 0) begin
                dec += b2 + two_b2 * col;
            end else begin
                dec += b2 + two_b2 * col - two_a2 * rw;
                queue_span(rw, col - 1);
                rw--;
            end
        end
        t   = 2 * col + 1;
        dec = ((b2 * t * t) >>> 2) + a2 * (rw - 1) * (rw - 1) - a2 * b2;
        while (rw >= 0) begin
            queue_span(rw, col);
            rw--;
            if (dec > 0) begin
                dec += a2 - two_a2 * rw;
            end else begin
                dec += a2 + two_b2 * col - two_a2 * rw;
                col++;
            end
        end
    endfunction

    always @(posedge i_clk) begin
        t_span_exp exp_span;
        if (i_rst_n) begin
            if (i_span.valid && i_span.ready) begin
                spans_checked++;
                if (expected_spans.size() == 0) begin
                    flag_mismatch($sformatf("span row=%0d hw=%0d with nothing expected",
                                            i_span.row, i_span.half_width));
                end else begin
                    exp_span = expected_spans.pop_front();
                    if (i_span.row !== exp_span.row)
                        flag_mismatch($sformatf("row got %0d want %0d",
                                                i_span.row, exp_span.row));
                    if (i_span.half_width !== exp_span.half_width)
                        flag_mismatch($sformatf("half_width got %0d want %0d (row %0d)",
                                                i_span.half_width, exp_span.half_width,
                                                exp_span.row));
                    if (i_span.last !== exp_span.last)
                        flag_mismatch($sformatf("last got %0b want %0b (row %0d)",
                                                i_span.last, exp_span.last, exp_span.row));
                end
            end
            if (i_req.valid && i_req.ready) begin
                requests++;
                predict_row_spans(i_req.radius_x, i_req.radius_y);
            end
        end
        o_pending <= expected_spans.size();
    end

endmodule

// ===== test/tb_ellipse_row_half_widths.sv =====
// Top-level bench: clock, reset, request and span stimulus, and the final verdict.
module tb_ellipse_row_half_widths;
    import erhw_pkg::*;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    erhw_req_if  req_ch ();
    erhw_span_if span_ch ();

    int  fail_count;
    int  spans_pending;
    int  spans_checked;
    int  requests_seen;
    bit  hold_armed = 1'b0;
    bit  hold_done  = 1'b0;

    int  directed_x[20] = '{0, 63, 0, 63, 1, 1, 63, 0, 1, 2,
                            3, 10, 5, 31, 32, 62, 63, 20, 1, 2};
    int  directed_y[20] = '{0, 63, 63, 0, 1, 63, 1, 1, 0, 3,
                            2, 5, 10, 32, 31, 63, 62, 20, 2, 1};

    always #5 i_clk = ~i_clk;

    ellipse_row_half_widths DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_span  (span_ch)
    );

    erhw_span_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req           (req_ch),
        .i_span          (span_ch),
        .o_fail_count    (fail_count),
        .o_pending       (spans_pending),
        .o_spans_checked (spans_checked),
        .o_requests      (requests_seen)
    );

    initial begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // holds valid high until the transfer; valid is left up for the caller
    task automatic send_radii(input logic [RAD_W-1:0] rx, input logic [RAD_W-1:0] ry);
        req_ch.valid    <= 1'b1;
        req_ch.radius_x <= rx;
        req_ch.radius_y <= ry;
        @(posedge i_clk);
        while (!req_ch.ready)
            @(posedge i_clk);
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (spans_pending != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [RAD_W-1:0] pick_radius();
        int sel;
        sel = $urandom_range(9);
        if (sel == 0)
            return '0;
        if (sel == 1)
            return RADIUS_MAX;
        if (sel == 2)
            return RAD_W'($urandom_range(3));
        return RAD_W'($urandom_range(63));
    endfunction

    // span receiver: ready duty changes from mode to mode at random, one long hold-off
    initial begin
        int ready_pct;
        int mode_left;
        span_ch.ready <= 1'b0;
        ready_pct = 100;
        mode_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_armed && !hold_done) begin
                span_ch.ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_done = 1'b1;
            end
            if (mode_left == 0) begin
                case ($urandom_range(3))
                    0: ready_pct = 100;
                    1: ready_pct = 75;
                    2: ready_pct = 40;
                    default: ready_pct = 15;
                endcase
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            span_ch.ready <= ($urandom_range(99) < ready_pct);
        end
    end

    // request sender
    initial begin
        int burst_left;
        int gap;
        req_ch.valid    <= 1'b0;
        req_ch.radius_x <= '0;
        req_ch.radius_y <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // back to back, no gaps
        foreach (directed_x[k])
            send_radii(RAD_W'(directed_x[k]), RAD_W'(directed_y[k]));
        wait_drained();

        // output stalls for a long stretch while requests keep coming
        hold_armed = 1'b1;
        burst_left = 0;
        for (int n = 0; n < 450; n++) begin
            if (n == 240)
                wait_drained();
            send_radii(pick_radius(), pick_radius());
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 10);
                gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 30);
                if (gap > 0) begin
                    req_ch.valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end else begin
                burst_left--;
            end
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        $display("covered %0d requests with radii 0..63 on both axes, %0d spans compared,",
                 requests_seen, spans_checked);
        $display("under random bursts, output stalls, a 400-cycle hold-off and drained pauses");
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/erhw_pkg.sv
rtl/core/erhw_if.sv
rtl/core/erhw_sequencer.sv
rtl/core/erhw_datapath.sv
rtl/core/ellipse_row_half_widths.sv
test/erhw_span_checker.sv
test/tb_ellipse_row_half_widths.sv
